/* rtl/md5_pkg.sv */
`timescale 1ns / 1ps
package md5_pkg;
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0] PAD_START = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       end_of_message;
  } md5_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_PAD, ST_LEN, ST_OUT
  } md5_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    begin
      case ({r[5:4], r[1:0]})
        4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
        4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
        4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction
endpackage

/* rtl/md5_front.sv */
`timescale 1ns / 1ps
// Two-entry FIFO; decouples the producer from the hash core.
module md5_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  logic              carries_byte,
  input  logic              end_of_message,
  input  logic              valid,
  output logic              stall,
  output md5_pkg::md5_item_t q_item,
  output logic              q_valid,
  input  logic              q_take
);
  import md5_pkg::*;

  md5_item_t mem [QueueDepth];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;

  assign stall = (count == 2'(QueueDepth));
  // idle items do nothing, drop them here
  assign push = valid && !stall && (carries_byte || end_of_message);
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_take;
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= '{data_byte, carries_byte, end_of_message};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/md5_core.sv */
`timescale 1ns / 1ps
module md5_core (
  input  logic               clk,
  input  logic               rst,
  input  md5_pkg::md5_item_t q_item,
  input  logic               q_valid,
  output logic               q_take,
  output logic [63:0]        digest_low,
  output logic [63:0]        digest_high,
  output logic               out_valid,
  input  logic               out_stall
);
  import md5_pkg::*;

  md5_state_t  state, state_next, ret_state, after_round;
  logic [31:0] buf_w [16];
  logic [31:0] h0, h1, h2, h3, a, b, c, d;
  logic [63:0] bit_count, length;
  logic [5:0]  fill_index, rnd;
  logic [2:0]  lidx;
  logic        pad_first;    // next pad byte is the 0x80 marker
  logic        wr_now;
  logic [7:0]  byte_now;
  logic        blk_full;
  logic [31:0] f, sum, rot, mw;
  logic [3:0]  g;
  logic [4:0]  s;

  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd[3:0]; end
      2'd1: begin f = (b & d) | (c & ~d); g = 4'(5 * rnd + 1); end
      2'd2: begin f = b ^ c ^ d;          g = 4'(3 * rnd + 5); end
      default: begin f = c ^ (b | ~d);    g = 4'(7 * rnd); end
    endcase
    mw = buf_w[g];
    sum = a + f + round_k(rnd) + mw;
    s = round_s(rnd);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  // one byte per cycle enters the buffer, but none during rounds, output or an empty queue:
  // message byte, 0x80, zeros or length; a write into the last slot diverts to the rounds and returns to ret_state
  always_comb begin
    wr_now = 1'b0;
    byte_now = 8'h00;
    q_take = 1'b0;
    ret_state = state;
    unique case (state)
      ST_IDLE: begin
        q_take = 1'b1;
        if (q_valid) begin
          wr_now = q_item.carries_byte;
          byte_now = q_item.data_byte;
          ret_state = q_item.end_of_message ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (pad_first) begin
          wr_now = 1'b1;
          byte_now = PAD_START;
        end else if (fill_index != LEN_OFFSET) begin
          wr_now = 1'b1;
        end else begin
          ret_state = ST_LEN;
        end
      end
      ST_LEN: begin
        wr_now = 1'b1;
        byte_now = length[{lidx, 3'b000} +: 8];
        ret_state = (lidx == 3'd7) ? ST_OUT : ST_LEN;
      end
      ST_ROUND: ret_state = (rnd == 6'd63) ? after_round : ST_ROUND;
      ST_OUT: ret_state = out_stall ? ST_OUT : ST_IDLE;
      default: ret_state = ST_IDLE;
    endcase
    blk_full = wr_now && (fill_index == 6'd63);
    state_next = blk_full ? ST_ROUND : ret_state;
  end

  always_ff @(posedge clk) begin
    if (wr_now) buf_w[fill_index[5:2]][{fill_index[1:0], 3'b000} +: 8] <= byte_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      h0 <= IV0; h1 <= IV1; h2 <= IV2; h3 <= IV3;
      a <= '0; b <= '0; c <= '0; d <= '0;
      bit_count <= '0;
      length <= '0;
      fill_index <= '0;
      rnd <= '0;
      lidx <= '0;
      pad_first <= 1'b0;
      out_valid <= 1'b0;
      after_round <= ST_IDLE;
    end else begin
      state <= state_next;
      if (wr_now) fill_index <= fill_index + 6'd1;
      if (state == ST_IDLE && q_valid) begin
        if (q_item.carries_byte) bit_count <= bit_count + 64'd8;
        if (q_item.end_of_message) begin
          length <= bit_count + (q_item.carries_byte ? 64'd8 : 64'd0);
          pad_first <= 1'b1;
          lidx <= '0;
        end
      end
      if (state == ST_PAD && pad_first) pad_first <= 1'b0;
      if (state == ST_LEN) lidx <= lidx + 3'd1;
      if (state == ST_ROUND) begin
        a <= d; d <= c; c <= b; b <= b + rot;
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          h0 <= h0 + d;
          h1 <= h1 + b + rot;
          h2 <= h2 + b;
          h3 <= h3 + c;
          if (after_round == ST_OUT) out_valid <= 1'b1;
        end
      end
      if (blk_full) begin
        a <= h0; b <= h1; c <= h2; d <= h3;
        rnd <= '0;
        after_round <= ret_state;
      end
      if (state == ST_OUT && !out_stall) begin
        out_valid <= 1'b0;
        h0 <= IV0; h1 <= IV1; h2 <= IV2; h3 <= IV3;
        bit_count <= '0;
        fill_index <= '0;
      end
    end
  end

  assign digest_low = {h1, h0};
  assign digest_high = {h3, h2};
endmodule

/* rtl/md5_stream_hasher.sv */
`timescale 1ns / 1ps
// MD5 over a byte stream. A byte transfer is buffered in a two-entry queue; the
// core takes one item per cycle from it while it is idle and writes the byte into
// the block buffer. Every 64th byte starts the compression, one round per cycle,
// during which the queue fills and stalls the input. End of message pads one byte
// per cycle, then writes the 8 length bytes, with one or two compressions before
// the digest is shown; the digest register holds until taken and the core takes
// no new item meanwhile. Items with neither a byte nor end of message are dropped.
module md5_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        carries_byte,
  input  logic        end_of_message,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [63:0] digest_low,
  output logic [63:0] digest_high,
  output logic        out_valid,
  input  logic        out_stall
);
  import md5_pkg::*;

  md5_item_t q_item;
  logic q_valid, q_take;

  md5_front u_front (
    .clk, .rst, .data_byte, .carries_byte, .end_of_message,
    .valid(in_valid), .stall(in_stall), .q_item, .q_valid, .q_take
  );

  md5_core u_core (
    .clk, .rst, .q_item, .q_valid, .q_take,
    .digest_low, .digest_high, .out_valid, .out_stall
  );
endmodule
